// ----- src/imhq_pkg.sv -----
package imhq_pkg;

    // Sizing
    localparam int CAPACITY    = 64;
    localparam int KEY_BITS    = 16;
    localparam int NUM_HANDLES = 64;
    localparam int HANDLE_W    = 6;
    localparam int KEY_W       = 16;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 7;
    localparam int SLOT_W      = $clog2(CAPACITY + 1);
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int ENTRY_W     = HANDLE_W + KEY_BITS;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 32;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_POP    = 2'd2
    } kind_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE   = 3'd0,
        STAT_EMPTY  = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_DUP    = 3'd3,
        STAT_ABSENT = 3'd4
    } status_t;

    // One heap slot
    typedef struct packed {
        logic [HANDLE_W-1:0] h;
        logic [KEY_BITS-1:0] k;
    } entry_t;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_INS_START,
        OP_TAKE_START,
        OP_TAKE_LAST,
        OP_TAIL_RD,
        OP_TAKE_TAIL,
        OP_UP_RD,
        OP_UP_MOVE,
        OP_DN_RD_L,
        OP_DN_RD_R,
        OP_DN_MOVE_L,
        OP_DN_MOVE_R,
        OP_FIN,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    set_st;
        status_t st;
    } dp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              present;
        logic              full;
        logic              empty;
        logic              x_is_last;
        logic              gone_lt_tail;
        logic              n_is_root;
        logic              up_stop;
        logic              dn_leaf;
        logic              has_right;
        logic              left_stop;
        logic              right_stop;
        logic              out_busy;
    } dp_sts_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_TK1,
        ST_TK2,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_L,
        ST_DN_R,
        ST_FIN,
        ST_DONE
    } ctrl_state_t;

endpackage

// ----- src/imhq_ram.sv -----
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/imhq_ctrl.sv -----
module imhq_ctrl import imhq_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.set_st = 1'b0;
        cmd.st     = STAT_DONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                unique case (sts.kind)
                    KIND_INSERT:
                    begin
                        if (sts.present)
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = STAT_DUP;
                            state_next = ST_DONE;
                        end
                        else if (sts.full)
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = STAT_FULL;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_INS_START;
                            state_next = ST_UP_RD;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (!sts.present)
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = STAT_ABSENT;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_TAKE_START;
                            state_next = ST_TK1;
                        end
                    end
                    KIND_POP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = STAT_EMPTY;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_TAKE_START;
                            state_next = ST_TK1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_TK1:
            begin
                // hole at the tail: just shrink
                if (sts.x_is_last)
                begin
                    cmd.op     = OP_TAKE_LAST;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = OP_TAIL_RD;
                    state_next = ST_TK2;
                end
            end
            ST_TK2:
            begin
                cmd.op = OP_TAKE_TAIL;
                if (sts.gone_lt_tail)
                begin
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_DN_RD;
                end
            end
            ST_UP_RD:
            begin
                if (sts.n_is_root)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.op     = OP_UP_RD;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if (sts.up_stop)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.op     = OP_UP_MOVE;
                    state_next = ST_UP_RD;
                end
            end
            ST_DN_RD:
            begin
                if (sts.dn_leaf)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.op     = OP_DN_RD_L;
                    state_next = ST_DN_L;
                end
            end
            ST_DN_L:
            begin
                if (sts.has_right)
                begin
                    cmd.op     = OP_DN_RD_R;
                    state_next = ST_DN_R;
                end
                else if (sts.left_stop)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.op     = OP_DN_MOVE_L;
                    state_next = ST_DN_RD;
                end
            end
            ST_DN_R:
            begin
                if (sts.right_stop)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.op     = OP_DN_MOVE_R;
                    state_next = ST_DN_RD;
                end
            end
            ST_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!sts.out_busy)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/imhq_dp.sv -----
module imhq_dp import imhq_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [HANDLE_W-1:0] in_handle,
    input  logic [KEY_W-1:0]    in_key,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // out_handle, out_key, entry_count, zero pad
    output logic [STATUS_W-1:0] m_tuser   // status
);

    localparam logic [SLOT_W-1:0] SLOT_ONE = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_CAP = SLOT_W'(CAPACITY);

    // Control registers
    logic [SLOT_W-1:0]      size_reg, size_next;
    logic                   out_valid_reg, out_valid_next;
    logic [NUM_HANDLES-1:0] pos_valid_reg, pos_valid_next;

    // Payload registers
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [HANDLE_W-1:0] hnd_reg, hnd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [SLOT_W-1:0]   x_reg, x_next;
    logic [SLOT_W-1:0]   n_reg, n_next;
    entry_t              mov_reg, mov_next;
    entry_t              left_reg, left_next;
    logic [KEY_BITS-1:0] gone_reg, gone_next;
    status_t             st_reg, st_next;
    logic [HANDLE_W-1:0] outh_reg, outh_next;
    logic [KEY_BITS-1:0] outk_reg, outk_next;
    logic [HANDLE_W-1:0] res_h_reg, res_h_next;
    logic [KEY_BITS-1:0] res_k_reg, res_k_next;
    logic [COUNT_W-1:0]  res_cnt_reg, res_cnt_next;
    status_t             res_st_reg, res_st_next;
    logic                pos_rvld_reg;

    // Memory ports
    logic                heap_we, heap_re;
    logic [ADDR_W-1:0]   heap_waddr, heap_raddr;
    entry_t              heap_wdata;
    logic [ENTRY_W-1:0]  heap_rdata;
    entry_t              heap_rd;
    logic                pos_we, pos_re;
    logic [HANDLE_W-1:0] pos_waddr, pos_raddr;
    logic [SLOT_W-1:0]   pos_wdata, pos_rdata, pos_rd;

    // Derived values
    logic [SLOT_W-1:0] n2, n2p1, x_sel;
    logic              left_lt_right;
    entry_t            cand_r;

    imhq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .re    (heap_re),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    imhq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_HANDLES)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // Read data; a never-written position reads as absent
    assign heap_rd       = entry_t'(heap_rdata);
    assign pos_rd        = pos_rvld_reg ? pos_rdata : '0;
    assign n2            = {n_reg[SLOT_W-2:0], 1'b0};
    assign n2p1          = {n_reg[SLOT_W-2:0], 1'b1};
    assign left_lt_right = left_reg.k < heap_rd.k;
    assign cand_r        = left_lt_right ? heap_rd : left_reg;
    assign x_sel         = (kind_reg == KIND_POP) ? SLOT_ONE : pos_rd;

    // Status to the controller
    always_comb
    begin
        sts.kind         = kind_reg;
        sts.present      = pos_rd != '0;
        sts.full         = size_reg >= SLOT_CAP;
        sts.empty        = size_reg == '0;
        sts.x_is_last    = x_reg == size_reg;
        sts.gone_lt_tail = gone_reg < heap_rd.k;
        sts.n_is_root    = n_reg == SLOT_ONE;
        sts.up_stop      = heap_rd.k >= mov_reg.k;
        sts.dn_leaf      = n_reg > (size_reg >> 1);
        sts.has_right    = n2 < size_reg;
        sts.left_stop    = heap_rd.k < mov_reg.k;
        sts.right_stop   = cand_r.k < mov_reg.k;
        sts.out_busy     = out_valid_reg && !m_tready;
    end

    // Operation decode
    always_comb
    begin
        size_next      = size_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pos_valid_next = pos_valid_reg;
        kind_next      = kind_reg;
        hnd_next       = hnd_reg;
        key_next       = key_reg;
        x_next         = x_reg;
        n_next         = n_reg;
        mov_next       = mov_reg;
        left_next      = left_reg;
        gone_next      = gone_reg;
        st_next        = st_reg;
        outh_next      = outh_reg;
        outk_next      = outk_reg;
        res_h_next     = res_h_reg;
        res_k_next     = res_k_reg;
        res_cnt_next   = res_cnt_reg;
        res_st_next    = res_st_reg;
        heap_we        = 1'b0;
        heap_waddr     = ADDR_W'(n_reg - SLOT_ONE);
        heap_wdata     = mov_reg;
        heap_re        = 1'b0;
        heap_raddr     = '0;
        pos_we         = 1'b0;
        pos_waddr      = mov_reg.h;
        pos_wdata      = n_reg;
        pos_re         = 1'b0;
        pos_raddr      = in_handle;

        if (cmd.set_st)
        begin
            st_next = cmd.st;
        end

        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_ACCEPT:
            begin
                // look up the handle and the root at once
                kind_next = in_kind;
                hnd_next  = in_handle;
                key_next  = in_key[KEY_BITS-1:0];
                st_next   = STAT_DONE;
                outh_next = '0;
                outk_next = '0;
                pos_re    = 1'b1;
                heap_re   = 1'b1;
            end
            OP_INS_START:
            begin
                size_next  = size_reg + SLOT_ONE;
                n_next     = size_reg + SLOT_ONE;
                mov_next.h = hnd_reg;
                mov_next.k = key_reg;
            end
            OP_TAKE_START:
            begin
                x_next     = x_sel;
                pos_we     = 1'b1;
                pos_waddr  = (kind_reg == KIND_POP) ? heap_rd.h : hnd_reg;
                pos_wdata  = '0;
                heap_re    = 1'b1;
                heap_raddr = ADDR_W'(x_sel - SLOT_ONE);
                if (kind_reg == KIND_POP)
                begin
                    outh_next = heap_rd.h;
                    outk_next = heap_rd.k;
                end
            end
            OP_TAKE_LAST:
            begin
                size_next = size_reg - SLOT_ONE;
            end
            OP_TAIL_RD:
            begin
                gone_next  = heap_rd.k;
                heap_re    = 1'b1;
                heap_raddr = ADDR_W'(size_reg - SLOT_ONE);
            end
            OP_TAKE_TAIL:
            begin
                mov_next  = heap_rd;
                size_next = size_reg - SLOT_ONE;
                n_next    = x_reg;
            end
            OP_UP_RD:
            begin
                heap_re    = 1'b1;
                heap_raddr = ADDR_W'((n_reg >> 1) - SLOT_ONE);
            end
            OP_UP_MOVE:
            begin
                // parent moves down into the hole
                heap_we    = 1'b1;
                heap_wdata = heap_rd;
                pos_we     = 1'b1;
                pos_waddr  = heap_rd.h;
                n_next     = n_reg >> 1;
            end
            OP_DN_RD_L:
            begin
                heap_re    = 1'b1;
                heap_raddr = ADDR_W'(n2 - SLOT_ONE);
            end
            OP_DN_RD_R:
            begin
                left_next  = heap_rd;
                heap_re    = 1'b1;
                heap_raddr = ADDR_W'(n2p1 - SLOT_ONE);
            end
            OP_DN_MOVE_L:
            begin
                heap_we    = 1'b1;
                heap_wdata = heap_rd;
                pos_we     = 1'b1;
                pos_waddr  = heap_rd.h;
                n_next     = n2;
            end
            OP_DN_MOVE_R:
            begin
                // right child wins only when strictly larger
                heap_we    = 1'b1;
                heap_wdata = cand_r;
                pos_we     = 1'b1;
                pos_waddr  = cand_r.h;
                n_next     = left_lt_right ? n2p1 : n2;
            end
            OP_FIN:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            OP_RESULT:
            begin
                out_valid_next = 1'b1;
                res_h_next     = outh_reg;
                res_k_next     = outk_reg;
                res_cnt_next   = COUNT_W'(size_reg);
                res_st_next    = st_reg;
            end
            default:
            begin
            end
        endcase

        if (pos_we)
        begin
            pos_valid_next[pos_waddr] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
            pos_valid_reg <= '0;
        end
        else
        begin
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
            pos_valid_reg <= pos_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        hnd_reg     <= hnd_next;
        key_reg     <= key_next;
        x_reg       <= x_next;
        n_reg       <= n_next;
        mov_reg     <= mov_next;
        left_reg    <= left_next;
        gone_reg    <= gone_next;
        st_reg      <= st_next;
        outh_reg    <= outh_next;
        outk_reg    <= outk_next;
        res_h_reg   <= res_h_next;
        res_k_reg   <= res_k_next;
        res_cnt_reg <= res_cnt_next;
        res_st_reg  <= res_st_next;
        if (pos_re)
        begin
            pos_rvld_reg <= pos_valid_reg[pos_raddr];
        end
    end

    // Result port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({res_cnt_reg, KEY_W'(res_k_reg), res_h_reg});
    assign m_tuser  = res_st_reg;

endmodule

// ----- src/indexed_max_heap_queue.sv -----
// Transactions are taken one at a time, acceptance to next acceptance: a rejected
// item goes straight to its result; an insert climbs by parent compares towards the
// root; a remove or pop of the tail slot just shrinks the heap, else the tail entry
// fills the hole and climbs by parent compares or sinks by child pairs (or a lone left
// child) towards a leaf; one heap slot is read per cycle; a held result stalls the block.
// Reset: asynchronous, active low; heap empties, handles read absent via valid bits.
module indexed_max_heap_queue import imhq_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // handle, key, zero pad
    input  logic [KIND_W-1:0]   s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_handle, out_key, entry_count, zero pad
    output logic [STATUS_W-1:0] m_tuser    // status
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    imhq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    imhq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_kind   (s_tuser),
        .in_handle (s_tdata[HANDLE_W-1:0]),
        .in_key    (s_tdata[HANDLE_W+KEY_W-1:HANDLE_W]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- test/imhq_checker.sv -----
module imhq_checker import imhq_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // handle, key, zero pad
    input  logic [KIND_W-1:0]   s_tuser,   // kind
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // out_handle, out_key, entry_count, zero pad
    input  logic [STATUS_W-1:0] m_tuser,   // status
    output int                  fail_count,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One answer of the queue
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
        status_t             status;
        logic [COUNT_W-1:0]  count;
    } heap_answer_t;

    // Shadow heap: 1-based slots, slot index per handle (0 = absent)
    logic [HANDLE_W-1:0] heap_handle [1:CAPACITY];
    logic [KEY_BITS-1:0] heap_key    [1:CAPACITY];
    int unsigned         slot_of     [NUM_HANDLES];
    int unsigned         heap_fill;

    heap_answer_t answers_due [$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic void place_entry(int unsigned p, logic [HANDLE_W-1:0] h,
                                        logic [KEY_BITS-1:0] k);
        heap_handle[p] = h;
        heap_key[p]    = k;
        slot_of[h]     = p;
    endfunction

    // Move the entry at n towards the root; stops under a parent with key >= its own
    function automatic void climb(int unsigned n);
        logic [HANDLE_W-1:0] h;
        logic [KEY_BITS-1:0] k;
        int unsigned         p;
        h = heap_handle[n];
        k = heap_key[n];
        while (n > 1)
        begin
            p = n >> 1;
            if (heap_key[p] >= k)
                break;
            place_entry(n, heap_handle[p], heap_key[p]);
            n = p;
        end
        place_entry(n, h, k);
    endfunction

    // Move the entry at n towards the leaves; right child only if strictly larger,
    // and a child with an equal key still moves up
    function automatic void descend(int unsigned n);
        logic [HANDLE_W-1:0] h;
        logic [KEY_BITS-1:0] k;
        int unsigned         c;
        int unsigned         last;
        h    = heap_handle[n];
        k    = heap_key[n];
        last = heap_fill;
        while (n <= (last >> 1))
        begin
            c = n << 1;
            if (c < last && heap_key[c] < heap_key[c + 1])
                c++;
            if (heap_key[c] < k)
                break;
            place_entry(n, heap_handle[c], heap_key[c]);
            n = c;
        end
        place_entry(n, h, k);
    endfunction

    // Take a handle out, refill the hole with the tail entry and restore order
    function automatic void detach_handle(logic [HANDLE_W-1:0] h);
        int unsigned         x;
        logic [KEY_BITS-1:0] gone_key;
        logic [HANDLE_W-1:0] tail_h;
        logic [KEY_BITS-1:0] tail_k;
        x          = slot_of[h];
        slot_of[h] = 0;
        if (x == 0 || x > heap_fill)
            return;
        gone_key = heap_key[x];
        if (x == heap_fill)
        begin
            heap_fill--;
            return;
        end
        tail_h = heap_handle[heap_fill];
        tail_k = heap_key[heap_fill];
        heap_fill--;
        place_entry(x, tail_h, tail_k);
        if (gone_key < tail_k)
            climb(x);
        else
            descend(x);
    endfunction

    // Apply one transaction to the shadow heap and return the answer it should give
    function automatic heap_answer_t apply_item(logic [KIND_W-1:0] kd,
                                                logic [HANDLE_W-1:0] h,
                                                logic [KEY_W-1:0] k);
        heap_answer_t a;
        a        = '0;
        a.status = STAT_DONE;
        case (kd)
            KIND_INSERT:
            begin
                // duplicate is checked before full
                if (slot_of[h] != 0)
                    a.status = STAT_DUP;
                else if (heap_fill >= CAPACITY)
                    a.status = STAT_FULL;
                else
                begin
                    heap_fill++;
                    place_entry(heap_fill, h, k[KEY_BITS-1:0]);
                    climb(heap_fill);
                end
            end
            KIND_REMOVE:
            begin
                if (slot_of[h] == 0)
                    a.status = STAT_ABSENT;
                else
                    detach_handle(h);
            end
            KIND_POP:
            begin
                if (heap_fill == 0)
                    a.status = STAT_EMPTY;
                else
                begin
                    a.handle = heap_handle[1];
                    a.key    = KEY_W'(heap_key[1]);
                    detach_handle(heap_handle[1]);
                end
            end
            default: ;  // unused kind: no change
        endcase
        a.count = COUNT_W'(heap_fill);
        return a;
    endfunction

    task automatic report(string field, int want, int got);
        $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    // Watch both channels; results are checked before the new input is applied
    always @(posedge clk)
    begin : watch
        heap_answer_t want;
        heap_answer_t seen;
        if (!rst_n)
        begin
            foreach (slot_of[i])
                slot_of[i] = 0;
            heap_fill = 0;
            answers_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.handle = m_tdata[HANDLE_W-1:0];
                seen.key    = m_tdata[HANDLE_W +: KEY_W];
                seen.count  = m_tdata[HANDLE_W+KEY_W +: COUNT_W];
                seen.status = status_t'(m_tuser);
                if (answers_due.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual handle %0d key %0d status %0d count %0d",
                             $time, seen.handle, seen.key, seen.status, seen.count);
                    fail_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (seen.handle !== want.handle)
                        report("out_handle", want.handle, seen.handle);
                    if (seen.key !== want.key)
                        report("out_key", want.key, seen.key);
                    if (seen.status !== want.status)
                        report("status", want.status, seen.status);
                    if (seen.count !== want.count)
                        report("entry_count", want.count, seen.count);
                end
            end
            if (s_tvalid && s_tready)
                answers_due.push_back(apply_item(s_tuser, s_tdata[HANDLE_W-1:0],
                                                 s_tdata[HANDLE_W +: KEY_W]));
            outstanding = answers_due.size();
        end
    end

endmodule

// ----- test/tb_indexed_max_heap_queue.sv -----
module tb_indexed_max_heap_queue;
    import imhq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Kind with no meaning: answered without any change
    localparam logic [KIND_W-1:0] KIND_IDLE = 2'd3;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_WAIT   = 60;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    int                  fail_count;
    int                  outstanding;

    // Sender pacing and receiver hold-off request
    int unsigned burst_left = 0;
    bit          steady     = 1'b0;
    bit          hold_req   = 1'b0;
    int unsigned useful     = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    indexed_max_heap_queue uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    imhq_checker check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Keys biased towards the extremes and a narrow band that forces ties
    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return KEY_W'($urandom_range(0, 7));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // Offer one transaction and hold it until accepted; gaps come between bursts
    task automatic send_item(input logic [KIND_W-1:0] kd, input logic [HANDLE_W-1:0] hd,
                             input logic [KEY_W-1:0] ky);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-HANDLE_W-KEY_W){1'b0}}, ky, hd};
        s_tuser  <= kd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        if (kd != KIND_IDLE)
            useful++;
    endtask

    // Receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin : result_side
        int hold_left;
        int mode_left;
        int mode;
        hold_left = 0;
        mode_left = 0;
        mode      = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ((mode_left % 5) >= 2);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [HANDLE_W-1:0] next_handle;
        int                  pick;
        int                  target;
        next_handle = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KIND_INSERT;
        rst_n       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, absent remove, unused kind, extremes, ties, duplicate
        send_item(KIND_POP,    6'd0,  16'h0000);
        send_item(KIND_REMOVE, 6'd0,  16'h0000);
        send_item(KIND_IDLE,   6'd63, 16'hFFFF);
        send_item(KIND_INSERT, 6'd0,  16'h0000);
        send_item(KIND_INSERT, 6'd63, 16'hFFFF);
        send_item(KIND_INSERT, 6'd21, 16'hAAAA);
        send_item(KIND_INSERT, 6'd42, 16'h5555);
        send_item(KIND_INSERT, 6'd7,  16'hAAAA);
        send_item(KIND_INSERT, 6'd63, 16'h1234);
        send_item(KIND_INSERT, 6'd12, 16'hFFFF);
        send_item(KIND_INSERT, 6'd30, 16'h0001);
        send_item(KIND_REMOVE, 6'd42, 16'h0000);
        send_item(KIND_REMOVE, 6'd63, 16'h0000);
        send_item(KIND_REMOVE, 6'd63, 16'h0000);
        send_item(KIND_IDLE,   6'd0,  16'h0000);
        repeat (7) send_item(KIND_POP, 6'($urandom), KEY_W'($urandom));

        // Long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        target   = useful + RANDOM_ITEMS;
        while (useful < target)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 11) == 0)
                hold_req = 1'b1;
            case ($urandom_range(0, 3))
                // fill: mostly fresh-handle inserts, some pops; dup and full rejects
                0:
                    repeat (70)
                    begin
                        if ($urandom_range(0, 9) < 8)
                        begin
                            send_item(KIND_INSERT, next_handle, rand_key());
                            next_handle++;
                        end
                        else
                            send_item(KIND_POP, 6'($urandom), KEY_W'($urandom));
                    end
                // drain: mostly pops and removals, with the odd insert
                1:
                    repeat (40)
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 5)
                            send_item(KIND_POP, 6'($urandom), KEY_W'($urandom));
                        else if (pick < 9)
                            send_item(KIND_REMOVE, 6'($urandom), KEY_W'($urandom));
                        else
                            send_item(KIND_INSERT, 6'($urandom), rand_key());
                    end
                // mixed, with the odd unused kind
                2:
                    repeat (50)
                    begin
                        pick = $urandom_range(0, 19);
                        if (pick == 0)
                            send_item(KIND_IDLE, 6'($urandom), KEY_W'($urandom));
                        else if (pick < 10)
                            send_item(KIND_INSERT, 6'($urandom), rand_key());
                        else if (pick < 15)
                            send_item(KIND_REMOVE, 6'($urandom), KEY_W'($urandom));
                        else
                            send_item(KIND_POP, 6'($urandom), KEY_W'($urandom));
                    end
                // equal-key churn
                default:
                    repeat (50)
                    begin
                        pick = $urandom_range(0, 3);
                        if (pick < 2)
                        begin
                            send_item(KIND_INSERT, next_handle,
                                      KEY_W'($urandom_range(0, 3)));
                            next_handle++;
                        end
                        else if (pick == 2)
                            send_item(KIND_REMOVE, 6'($urandom), KEY_W'($urandom));
                        else
                            send_item(KIND_POP, 6'($urandom), KEY_W'($urandom));
                    end
            endcase
        end
        s_tvalid <= 1'b0;

        // Let the last results come out, then let the bench idle before the verdict
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("indexed_max_heap_queue: match");
        else
            $display("indexed_max_heap_queue: mismatch");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("indexed_max_heap_queue: mismatch");
        $finish;
    end

endmodule
